// File: design/qrs_pkg.sv
`default_nettype none

package qrs_pkg;

    localparam int COEFF_W   = 16;
    localparam int PROD_W    = 2 * COEFF_W;
    localparam int DISC_W    = 34;
    localparam int WORD_W    = 32;
    localparam int ROOT_FRAC = 16;
    localparam int SQ_STEPS  = 33;
    localparam int ROOT_W    = 33;
    localparam int REM_W     = 37;
    localparam int NUM_W     = 34;
    localparam int DEN_W     = 17;
    localparam int SUM_W     = 35;
    localparam int STAGES    = 3 + SQ_STEPS + 1 + NUM_W + 1;

    localparam logic [1:0] ST_REAL  = 2'd0;
    localparam logic [1:0] ST_CPLX  = 2'd1;
    localparam logic [1:0] ST_AZERO = 2'd2;

    typedef struct packed {
        logic [REM_W-1:0]          rem;
        logic [ROOT_W-1:0]         root;
        logic [DISC_W-1:0]         m;
        logic signed [COEFF_W-1:0] a;
        logic signed [COEFF_W-1:0] b;
        logic signed [DISC_W-1:0]  d;
        logic [1:0]                status;
    } t_sq;

    typedef struct packed {
        logic [DEN_W-1:0]         rem1;
        logic [DEN_W-1:0]         rem2;
        logic [NUM_W-1:0]         n1;
        logic [NUM_W-1:0]         n2;
        logic [DEN_W-1:0]         ud;
        logic                     neg1;
        logic                     neg2;
        logic signed [DISC_W-1:0] d;
        logic [1:0]               status;
    } t_dv;

    function automatic logic [WORD_W-1:0] sat_word(input logic [NUM_W-1:0] q,
                                                   input logic neg);
        logic [WORD_W-1:0] res;
        if (neg) begin
            if (q >= NUM_W'(64'h8000_0000)) begin
                res = {1'b1, {(WORD_W-1){1'b0}}};
            end else begin
                res = WORD_W'(-q[WORD_W-1:0]);
            end
        end else begin
            if (q > NUM_W'(64'h7FFF_FFFF)) begin
                res = {1'b0, {(WORD_W-1){1'b1}}};
            end else begin
                res = q[WORD_W-1:0];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: design/quadratic_root_solver.sv
// Order of stages: input, products, discriminant, square root, setup, divide, output.
// Throughput: one transaction per cycle while the pipeline advances; it advances whenever
// its last stage is empty or the output is not stalled.
// The depth is set by the 33 one-bit square root stages and the 34 one-bit divide stages.
// Reset is synchronous and active low; it clears all valid bits, payload is not reset.
`default_nettype none

module quadratic_root_solver import qrs_pkg::*; (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_stall,
    input  wire signed [COEFF_W-1:0]   i_coeff_a,
    input  wire signed [COEFF_W-1:0]   i_coeff_b,
    input  wire signed [COEFF_W-1:0]   i_coeff_c,
    output logic                       o_valid,
    input  wire                        i_stall,
    output logic [1:0]                 o_status,
    output logic signed [DISC_W-1:0]   o_discriminant,
    output logic signed [WORD_W-1:0]   o_first_value,
    output logic signed [WORD_W-1:0]   o_second_value
);

    logic                      ce;
    logic [STAGES-1:0]         r_vld;

    logic signed [COEFF_W-1:0] r_a1, r_b1, r_c1;
    logic signed [COEFF_W-1:0] r_a2, r_b2;
    logic signed [PROD_W-1:0]  r_pbb, r_pac;
    t_sq                       n_s3, r_s3;
    t_sq                       r_sq [SQ_STEPS];
    t_dv                       n_pp, r_pp;
    t_dv                       r_dv [NUM_W];

    assign ce      = !(r_vld[STAGES-1] && i_stall);
    assign o_stall = !ce;
    assign o_valid = r_vld[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_a1  <= i_coeff_a;
            r_b1  <= i_coeff_b;
            r_c1  <= i_coeff_c;
            r_a2  <= r_a1;
            r_b2  <= r_b1;
            r_pbb <= r_b1 * r_b1;
            r_pac <= r_a1 * r_c1;
            r_s3  <= n_s3;
        end
    end

    always_comb begin
        logic signed [DISC_W-1:0] d;
        d = DISC_W'(r_pbb) - (DISC_W'(r_pac) <<< 2);
        n_s3.rem  = '0;
        n_s3.root = '0;
        n_s3.m    = d[DISC_W-1] ? DISC_W'(-d) : d;
        n_s3.a    = r_a2;
        n_s3.b    = r_b2;
        n_s3.d    = d;
        if (r_a2 == '0) begin
            n_s3.status = ST_AZERO;
        end else if (d[DISC_W-1]) begin
            n_s3.status = ST_CPLX;
        end else begin
            n_s3.status = ST_REAL;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        t_sq src, nxt;
        if (k == 0) begin : g_first
            assign src = r_s3;
        end else begin : g_rest
            assign src = r_sq[k-1];
        end
        always_comb begin
            logic [REM_W-1:0] t_rem;
            logic [REM_W-1:0] trial;
            t_rem = {src.rem[REM_W-3:0], src.m[DISC_W-1 -: 2]};
            trial = REM_W'({src.root, 2'b01});
            nxt   = src;
            nxt.m = {src.m[DISC_W-3:0], 2'b00};
            if (t_rem >= trial) begin
                nxt.rem  = t_rem - trial;
                nxt.root = {src.root[ROOT_W-2:0], 1'b1};
            end else begin
                nxt.rem  = t_rem;
                nxt.root = {src.root[ROOT_W-2:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_sq[k] <= nxt;
            end
        end
    end

    always_comb begin
        t_sq                      q;
        logic signed [SUM_W-1:0]  nb, s, sum, dif;
        logic                     a_neg;
        q     = r_sq[SQ_STEPS-1];
        a_neg = q.a[COEFF_W-1];
        nb    = -(SUM_W'(q.b) <<< ROOT_FRAC);
        s     = SUM_W'(q.root);
        sum   = nb + s;
        dif   = nb - s;
        n_pp.rem1   = '0;
        n_pp.rem2   = '0;
        n_pp.ud     = a_neg ? DEN_W'(-{q.a, 1'b0}) : DEN_W'({q.a, 1'b0});
        n_pp.d      = q.d;
        n_pp.status = q.status;
        if (q.status == ST_CPLX) begin
            n_pp.n1   = nb[SUM_W-1] ? NUM_W'(-nb) : NUM_W'(nb);
            n_pp.neg1 = nb[SUM_W-1] ^ a_neg;
            n_pp.n2   = NUM_W'(q.root);
            n_pp.neg2 = 1'b0;
        end else begin
            n_pp.n1   = sum[SUM_W-1] ? NUM_W'(-sum) : NUM_W'(sum);
            n_pp.neg1 = sum[SUM_W-1] ^ a_neg;
            n_pp.n2   = dif[SUM_W-1] ? NUM_W'(-dif) : NUM_W'(dif);
            n_pp.neg2 = dif[SUM_W-1] ^ a_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_pp <= n_pp;
        end
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_dv
        t_dv src, nxt;
        if (k == 0) begin : g_first
            assign src = r_pp;
        end else begin : g_rest
            assign src = r_dv[k-1];
        end
        always_comb begin
            logic [DEN_W:0] t1, t2;
            t1  = {src.rem1, src.n1[NUM_W-1]};
            t2  = {src.rem2, src.n2[NUM_W-1]};
            nxt = src;
            if (t1 >= {1'b0, src.ud}) begin
                nxt.rem1 = DEN_W'(t1 - {1'b0, src.ud});
                nxt.n1   = {src.n1[NUM_W-2:0], 1'b1};
            end else begin
                nxt.rem1 = DEN_W'(t1);
                nxt.n1   = {src.n1[NUM_W-2:0], 1'b0};
            end
            if (t2 >= {1'b0, src.ud}) begin
                nxt.rem2 = DEN_W'(t2 - {1'b0, src.ud});
                nxt.n2   = {src.n2[NUM_W-2:0], 1'b1};
            end else begin
                nxt.rem2 = DEN_W'(t2);
                nxt.n2   = {src.n2[NUM_W-2:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_dv[k] <= nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            o_status       <= r_dv[NUM_W-1].status;
            o_discriminant <= r_dv[NUM_W-1].d;
            if (r_dv[NUM_W-1].status == ST_AZERO) begin
                o_first_value  <= '0;
                o_second_value <= '0;
            end else begin
                o_first_value  <= sat_word(r_dv[NUM_W-1].n1, r_dv[NUM_W-1].neg1);
                o_second_value <= sat_word(r_dv[NUM_W-1].n2, r_dv[NUM_W-1].neg2);
            end
        end
    end

endmodule

`default_nettype wire

// File: bench/quadratic_root_solver_tb.sv
`timescale 1ns / 100ps

module quadratic_root_solver_tb;
    import qrs_pkg::*;

    typedef struct {
        logic [1:0]               status;
        logic signed [DISC_W-1:0] disc;
        logic signed [WORD_W-1:0] x1;
        logic signed [WORD_W-1:0] x2;
    } roots_t;

    typedef struct {
        logic signed [COEFF_W-1:0] a;
        logic signed [COEFF_W-1:0] b;
        logic signed [COEFF_W-1:0] c;
        bit                        typed;
        roots_t                    want;
    } equation_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic signed [COEFF_W-1:0] i_coeff_a = '0;
    logic signed [COEFF_W-1:0] i_coeff_b = '0;
    logic signed [COEFF_W-1:0] i_coeff_c = '0;
    logic o_stall;
    logic o_valid;
    logic [1:0] o_status;
    logic signed [DISC_W-1:0] o_discriminant;
    logic signed [WORD_W-1:0] o_first_value;
    logic signed [WORD_W-1:0] o_second_value;

    roots_t pending_roots[$];
    int send_idle_pct = 0;
    int stall_pct = 0;
    int errors = 0;
    longint cycles = 0;

    quadratic_root_solver DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_coeff_a(i_coeff_a),
        .i_coeff_b(i_coeff_b),
        .i_coeff_c(i_coeff_c),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_status(o_status),
        .o_discriminant(o_discriminant),
        .o_first_value(o_first_value),
        .o_second_value(o_second_value)
    );

    always #6 i_clk = ~i_clk;

    function automatic longint scaled_sqrt(longint mag);
        logic [71:0] target;
        logic [71:0] acc;
        logic [71:0] trial;
        target = 72'(mag) << (2 * ROOT_FRAC);
        acc = '0;
        for (int i = 35; i >= 0; i--) begin
            trial = acc | (72'd1 << i);
            if (trial * trial <= target) begin
                acc = trial;
            end
        end
        return longint'(acc);
    endfunction

    function automatic logic signed [WORD_W-1:0] clamp_div(longint num, longint den);
        longint un;
        longint ud;
        longint q;
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        q = un / ud;
        if ((num < 0) != (den < 0)) begin
            if (q >= 64'h8000_0000) begin
                return 32'sh8000_0000;
            end
            return WORD_W'(-q);
        end
        if (q > 64'h7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end
        return WORD_W'(q);
    endfunction

    function automatic roots_t solve_roots(logic signed [COEFF_W-1:0] a,
                                           logic signed [COEFF_W-1:0] b,
                                           logic signed [COEFF_W-1:0] c);
        roots_t r;
        longint la;
        longint lb;
        longint lc;
        longint d;
        longint s;
        longint nb;
        la = a;
        lb = b;
        lc = c;
        d = lb * lb - 4 * la * lc;
        r.disc = DISC_W'(d);
        r.x1 = '0;
        r.x2 = '0;
        nb = -lb * (64'sd1 << ROOT_FRAC);
        if (la == 0) begin
            r.status = ST_AZERO;
        end else if (d >= 0) begin
            s = scaled_sqrt(d);
            r.status = ST_REAL;
            r.x1 = clamp_div(nb + s, 2 * la);
            r.x2 = clamp_div(nb - s, 2 * la);
        end else begin
            s = scaled_sqrt(-d);
            r.status = ST_CPLX;
            r.x1 = clamp_div(nb, 2 * la);
            r.x2 = clamp_div(s, (la < 0 ? -2 * la : 2 * la));
        end
        return r;
    endfunction

    task automatic send_equation(logic signed [COEFF_W-1:0] a,
                                 logic signed [COEFF_W-1:0] b,
                                 logic signed [COEFF_W-1:0] c,
                                 bit typed, roots_t want);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_coeff_a <= a;
        i_coeff_b <= b;
        i_coeff_c <= c;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        pending_roots.push_back(typed ? want : solve_roots(a, b, c));
    endtask

    function automatic logic signed [COEFF_W-1:0] pick_coeff();
        case ($urandom_range(5))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return -16'sd1;
            3: return 16'sd1;
            4: return 16'sd0;
            default: return COEFF_W'($urandom_range(65535));
        endcase
    endfunction

    task automatic random_equation();
        logic signed [COEFF_W-1:0] a;
        logic signed [COEFF_W-1:0] b;
        logic signed [COEFF_W-1:0] c;
        roots_t none;
        none = '{default: '0};
        a = COEFF_W'($urandom_range(65535));
        b = COEFF_W'($urandom_range(65535));
        c = COEFF_W'($urandom_range(65535));
        case ($urandom_range(9))
            4, 5, 6: begin
                a = COEFF_W'(int'($urandom_range(4096)) - 2048);
                b = COEFF_W'(int'($urandom_range(4096)) - 2048);
                c = COEFF_W'(int'($urandom_range(4096)) - 2048);
            end
            7: a = '0;
            8: begin
                a = pick_coeff();
                b = pick_coeff();
                c = pick_coeff();
            end
            default: ;
        endcase
        send_equation(a, b, c, 1'b0, none);
    endtask

    always @(posedge i_clk) begin
        i_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        roots_t w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_roots.size() == 0) begin
                $display("%0t: unexpected result status=%0d", $time, o_status);
                errors++;
            end else begin
                w = pending_roots.pop_front();
                if (o_status !== w.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, w.status, o_status);
                    errors++;
                end
                if (o_discriminant !== w.disc) begin
                    $display("%0t: discriminant expected %0d actual %0d",
                             $time, w.disc, o_discriminant);
                    errors++;
                end
                if (o_first_value !== w.x1) begin
                    $display("%0t: first_value expected %0d actual %0d",
                             $time, w.x1, o_first_value);
                    errors++;
                end
                if (o_second_value !== w.x2) begin
                    $display("%0t: second_value expected %0d actual %0d",
                             $time, w.x2, o_second_value);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    equation_t directed[] = '{
        '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{ST_AZERO, 34'sd0, 32'sd0, 32'sd0}},
        '{16'sd0, -16'sd32768, 16'sd5, 1'b1, '{ST_AZERO, 34'sd1073741824, 32'sd0, 32'sd0}},
        '{16'sd0, 16'sd32767, -16'sd32768, 1'b1,
          '{ST_AZERO, 34'sd1073676289, 32'sd0, 32'sd0}},
        '{16'sd256, 16'sd0, -16'sd256, 1'b1,
          '{ST_REAL, 34'sd262144, 32'sd65536, -32'sd65536}},
        '{16'sd256, 16'sd512, 16'sd256, 1'b1,
          '{ST_REAL, 34'sd0, -32'sd65536, -32'sd65536}},
        '{16'sd256, 16'sd0, 16'sd256, 1'b1,
          '{ST_CPLX, -34'sd262144, 32'sd0, 32'sd65536}},
        '{16'sd1, -16'sd32768, 16'sd0, 1'b0, '{default: '0}},
        '{16'sd1, 16'sd32767, 16'sd0, 1'b0, '{default: '0}},
        '{-16'sd1, -16'sd32768, 16'sd0, 1'b0, '{default: '0}},
        '{16'sd1, 16'sd0, 16'sd32767, 1'b0, '{default: '0}},
        '{-16'sd32768, 16'sd0, 16'sd32767, 1'b0, '{default: '0}},
        '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '{default: '0}},
        '{-16'sd32768, 16'sd0, -16'sd32768, 1'b0, '{default: '0}},
        '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '{default: '0}},
        '{16'sd32767, -16'sd32768, -16'sd32768, 1'b0, '{default: '0}},
        '{16'sd1, 16'sd1, 16'sd1, 1'b0, '{default: '0}},
        '{-16'sd1, -16'sd1, -16'sd1, 1'b0, '{default: '0}},
        '{16'sd768, -16'sd1280, 16'sd512, 1'b0, '{default: '0}},
        '{-16'sd300, 16'sd77, 16'sd4000, 1'b0, '{default: '0}},
        '{16'sd2, -16'sd32768, 16'sd1, 1'b0, '{default: '0}}
    };

    initial begin
        int idle_plan[4];
        int stall_plan[4];
        idle_plan = '{0, 68, 0, 19};
        stall_plan = '{0, 0, 68, 19};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i]) begin
            send_equation(directed[i].a, directed[i].b, directed[i].c,
                          directed[i].typed, directed[i].want);
        end
        for (int p = 0; p < 4; p++) begin
            i_valid <= 1'b0;
            while (pending_roots.size() != 0) @(posedge i_clk);
            send_idle_pct = idle_plan[p];
            stall_pct = stall_plan[p];
            repeat (100) random_equation();
        end
        i_valid <= 1'b0;
        while (pending_roots.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
